// ===== design/mbe_pkg.sv =====
package mbe_pkg;

	localparam int FRAC_BITS = 28;
	localparam int IN_W      = 32;
	localparam int CNT_W     = 16;
	localparam int OUT_W     = 36;
	// working width of z and of the intermediate sums
	localparam int ZW        = 40;
	// operand magnitudes stay below 2^32 on every path, see core
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 2 * MUL_W;

	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(256);

	typedef struct packed {
		logic signed [IN_W-1:0] point_re;
		logic signed [IN_W-1:0] point_im;
	} point_t;

	typedef struct packed {
		logic [CNT_W-1:0]        iterations;
		logic                    inside_res;
		logic signed [OUT_W-1:0] final_re;
		logic signed [OUT_W-1:0] final_im;
	} result_t;

	typedef struct packed {
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
		logic             neg;
	} mul_req_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic              neg;
	} mul_rsp_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_stat_t;

endpackage

// ===== design/mbe_mul.sv =====
module mbe_mul (
	input  logic              clk,
	input  mbe_pkg::mul_req_t req,
	output mbe_pkg::mul_rsp_t rsp
);

	mbe_pkg::mul_rsp_t rsp_q;

	// unsigned magnitude product, sign carried alongside
	always_ff @(posedge clk) begin
		rsp_q.prod <= req.a * req.b;
		rsp_q.neg  <= req.neg;
	end

	assign rsp = rsp_q;

endmodule

// ===== design/mbe_core.sv =====
module mbe_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  mbe_pkg::point_t                   point,
	input  logic [mbe_pkg::CNT_W-1:0]         limit,
	input  logic                              take,
	output mbe_pkg::core_stat_t               stat,
	output mbe_pkg::result_t                  res,
	output mbe_pkg::mul_req_t                 mul_req,
	input  mbe_pkg::mul_rsp_t                 mul_rsp
);

	localparam int ZW = mbe_pkg::ZW;

	localparam logic signed [ZW-1:0] FIX_ONE      = ZW'(1) <<< mbe_pkg::FRAC_BITS;
	localparam logic signed [ZW-1:0] FIX_QUARTER  = ZW'(1) <<< (mbe_pkg::FRAC_BITS - 2);
	localparam logic signed [ZW-1:0] FIX_SIXTEEN  = ZW'(1) <<< (mbe_pkg::FRAC_BITS - 4);
	localparam logic signed [ZW-1:0] FIX_TWO      = FIX_ONE <<< 1;
	localparam logic signed [ZW-1:0] FIX_FOUR     = FIX_ONE <<< 2;
	localparam logic signed [ZW-1:0] FIX_TEN      = FIX_ONE * ZW'(10);
	localparam logic signed [ZW-1:0] OUT_MAX      = (ZW'(1) <<< (mbe_pkg::OUT_W - 1)) - ZW'(1);
	localparam logic signed [ZW-1:0] OUT_MIN      = -(ZW'(1) <<< (mbe_pkg::OUT_W - 1));

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SC_II,
		ST_SC_TT,
		ST_SC_BB,
		ST_SC_Q,
		ST_SC_QT,
		ST_SC_CMP,
		ST_IT_XY,
		ST_IT_Y,
		ST_IT_XX,
		ST_IT_YY,
		ST_IT_CHK,
		ST_DONE
	} state_t;

	function automatic logic [ZW-1:0] mag(input logic signed [ZW-1:0] v);
		return v[ZW-1] ? -v : v;
	endfunction

	function automatic mbe_pkg::mul_req_t mul_op(input logic signed [ZW-1:0] a,
		input logic signed [ZW-1:0] b);
		logic [ZW-1:0]     am;
		logic [ZW-1:0]     bm;
		mbe_pkg::mul_req_t r;
		am    = mag(a);
		bm    = mag(b);
		r.a   = am[mbe_pkg::MUL_W-1:0];
		r.b   = bm[mbe_pkg::MUL_W-1:0];
		r.neg = a[ZW-1] ^ b[ZW-1];
		return r;
	endfunction

	function automatic logic signed [mbe_pkg::OUT_W-1:0] sat(input logic signed [ZW-1:0] v);
		logic signed [ZW-1:0] c;
		c = v;
		if (v > OUT_MAX) c = OUT_MAX;
		if (v < OUT_MIN) c = OUT_MIN;
		return c[mbe_pkg::OUT_W-1:0];
	endfunction

	state_t                        state_q;
	logic signed [mbe_pkg::IN_W-1:0] cr_q;
	logic signed [mbe_pkg::IN_W-1:0] ci_q;
	logic signed [ZW-1:0]          x_q;
	logic signed [ZW-1:0]          y_q;
	logic signed [ZW-1:0]          xsq_q;
	logic signed [ZW-1:0]          ysq_q;
	logic signed [ZW-1:0]          isq_q;
	logic signed [ZW-1:0]          tt_q;
	logic signed [ZW-1:0]          q_q;
	logic signed [ZW-1:0]          qt_q;
	logic                          bulb_q;
	logic [mbe_pkg::CNT_W-1:0]     n_q;

	logic signed [ZW-1:0] cr_w;
	logic signed [ZW-1:0] ci_w;
	logic signed [ZW-1:0] t_w;
	logic signed [ZW-1:0] bx_w;
	logic signed [ZW-1:0] fmag;
	logic signed [ZW-1:0] fres;
	logic signed [ZW-1:0] x_new;
	logic signed [ZW-1:0] y_new;
	logic                 far;
	logic                 big;
	logic                 card;
	logic                 esc;

	assign cr_w = ZW'(cr_q);
	assign ci_w = ZW'(ci_q);
	assign t_w  = cr_w - FIX_QUARTER;
	assign bx_w = cr_w + FIX_ONE;

	// product >> FRAC_BITS, truncated toward zero
	assign fmag = ZW'(mul_rsp.prod[mbe_pkg::PROD_W-1:mbe_pkg::FRAC_BITS]);
	assign fres = mul_rsp.neg ? -fmag : fmag;

	assign far   = (mag(cr_w) >= FIX_TWO) || (mag(ci_w) >= FIX_TWO);
	assign x_new = xsq_q - ysq_q + cr_w;
	assign y_new = (fres <<< 1) + ci_w;
	assign big   = (mag(x_new) >= FIX_FOUR) || (mag(y_new) >= FIX_FOUR);
	assign card  = fres < (isq_q >>> 2);
	assign esc   = (xsq_q + fres) >= FIX_TEN;

	always_comb begin
		mul_req = '0;
		unique case (state_q)
			ST_SC_II:  mul_req = mul_op(ci_w, ci_w);
			ST_SC_TT:  mul_req = mul_op(t_w, t_w);
			ST_SC_BB:  mul_req = mul_op(bx_w, bx_w);
			ST_SC_QT:  mul_req = mul_op(q_q, qt_q);
			ST_IT_XY:  mul_req = mul_op(x_q, y_q);
			ST_IT_XX:  mul_req = mul_op(x_q, x_q);
			ST_IT_YY:  mul_req = mul_op(y_q, y_q);
			// next x*y goes out while the escape test runs
			ST_IT_CHK: mul_req = mul_op(x_q, y_q);
			default:   mul_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cr_q    <= '0;
			ci_q    <= '0;
			x_q     <= '0;
			y_q     <= '0;
			xsq_q   <= '0;
			ysq_q   <= '0;
			isq_q   <= '0;
			tt_q    <= '0;
			q_q     <= '0;
			qt_q    <= '0;
			bulb_q  <= 1'b0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cr_q    <= point.point_re;
						ci_q    <= point.point_im;
						state_q <= ST_SC_II;
					end
				end
				ST_SC_II: begin
					if (far) begin
						x_q     <= '0;
						y_q     <= '0;
						xsq_q   <= '0;
						ysq_q   <= '0;
						n_q     <= '0;
						state_q <= (limit == '0) ? ST_DONE : ST_IT_XY;
					end else begin
						state_q <= ST_SC_TT;
					end
				end
				ST_SC_TT: begin
					isq_q   <= fres;
					state_q <= ST_SC_BB;
				end
				ST_SC_BB: begin
					tt_q    <= fres;
					state_q <= ST_SC_Q;
				end
				ST_SC_Q: begin
					bulb_q  <= (fres + isq_q) < FIX_SIXTEEN;
					q_q     <= tt_q + isq_q;
					qt_q    <= tt_q + isq_q + t_w;
					state_q <= ST_SC_QT;
				end
				ST_SC_QT: begin
					state_q <= ST_SC_CMP;
				end
				ST_SC_CMP: begin
					if (card || bulb_q) begin
						x_q     <= cr_w;
						y_q     <= ci_w;
						n_q     <= limit;
						state_q <= ST_DONE;
					end else begin
						x_q     <= '0;
						y_q     <= '0;
						xsq_q   <= '0;
						ysq_q   <= '0;
						n_q     <= '0;
						state_q <= (limit == '0) ? ST_DONE : ST_IT_XY;
					end
				end
				ST_IT_XY: begin
					state_q <= ST_IT_Y;
				end
				ST_IT_Y: begin
					x_q     <= x_new;
					y_q     <= y_new;
					n_q     <= n_q + 1'b1;
					// a component of 4 or more escapes without squaring
					state_q <= big ? ST_DONE : ST_IT_XX;
				end
				ST_IT_XX: begin
					state_q <= ST_IT_YY;
				end
				ST_IT_YY: begin
					xsq_q   <= fres;
					state_q <= ST_IT_CHK;
				end
				ST_IT_CHK: begin
					ysq_q <= fres;
					if (esc || n_q >= limit) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_IT_Y;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	assign res.iterations = n_q;
	assign res.inside_res = (n_q == limit);
	assign res.final_re   = sat(x_q);
	assign res.final_im   = sat(y_q);

endmodule

// ===== design/mandelbrot_escape_time.sv =====
// Flow per point: a far point (|re| or |im| >= 2) skips the cardioid and period-2 bulb test;
// a point inside either, or a zero limit, ends without iterating; else the orbit runs for N
// iterations, stopping at the limit, at |z|^2 >= 10 or when a component reaches 4 or more.
// One point at a time; each iteration uses the shared multiplier for x*y, x*x and y*y.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, iteration_limit = 256.
module mandelbrot_escape_time (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_ready,
	input  mbe_pkg::point_t               point,
	output logic                          result_valid,
	input  logic                          result_ready,
	output mbe_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mbe_pkg::CNT_W-1:0]     cfg_data
);

	logic [mbe_pkg::CNT_W-1:0] limit_q;
	logic                      result_valid_q;
	mbe_pkg::result_t          result_q;
	mbe_pkg::core_stat_t       stat;
	mbe_pkg::result_t          core_res;
	mbe_pkg::mul_req_t         mul_req;
	mbe_pkg::mul_rsp_t         mul_rsp;
	logic                      take;

	assign cfg_ready   = 1'b1;
	assign point_ready = stat.idle;
	assign take        = stat.done && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mbe_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= core_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	mbe_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (point_valid && point_ready),
		.point   (point),
		.limit   (limit_q),
		.take    (take),
		.stat    (stat),
		.res     (core_res),
		.mul_req (mul_req),
		.mul_rsp (mul_rsp)
	);

	mbe_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.rsp (mul_rsp)
	);

endmodule

// ===== design/mbe_check.sv =====
module mbe_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      point_valid,
	input logic                      point_ready,
	input mbe_pkg::point_t           point,
	input logic                      result_valid,
	input logic                      result_ready,
	input mbe_pkg::result_t          result,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [mbe_pkg::CNT_W-1:0] cfg_data
);

	logic [mbe_pkg::CNT_W-1:0] limit_q;

	// shadow of the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mbe_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready |=> !point_ready)
		else $error("request taken while a point is in work");

	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.inside_res == (result.iterations == limit_q)))
		else $error("inside flag disagrees with count and limit");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready && !result_valid |=> !result_valid)
		else $error("result appeared right after a request");

	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> point_valid && $stable(point))
		else $error("request dropped or changed while stalled");

endmodule

bind mandelbrot_escape_time mbe_check u_mbe_check (.*);
